>>> hw/rtl/indexed_min_heap_engine_defines.svh
// Assertion macros shared by the heap engine RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef INDEXED_MIN_HEAP_ENGINE_DEFINES_SVH
`define INDEXED_MIN_HEAP_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IMH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define IMH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/imh_pkg.sv
// Package for the indexed min-heap engine: field widths, codes, types.
// Used by every module of the engine; depends on nothing.
`default_nettype none
package imh_pkg;
   localparam int MODE_W     = 2;
   localparam int KEY_W      = 62;
   localparam int EDGE_ID_W  = 10;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 9;
   localparam int CAPACITY_DEF = 256;
   localparam int ID_SPACE_DEF = 1024;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_ERASE  = 2'd1,
      MODE_POP    = 2'd2,
      MODE_PEEK   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_DUPLICATE = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_EMPTY     = 3'd3,
      STAT_FULL      = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_RM_CMP,
      ST_RM_UP,
      ST_UP_CMP,
      ST_DN_CMP,
      ST_PLACE,
      ST_FIN,
      ST_OUT
   } state_type;

   // One heap slot: key and edge id.
   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [EDGE_ID_W-1:0] id;
   } slot_type;

   // Heap order: smaller key first, lower id first on equal keys.
   function automatic logic ranks_before(input slot_type a, input slot_type b);
      logic res;
      if (a.key != b.key) begin
         res = (a.key < b.key);
      end else begin
         res = (a.id < b.id);
      end
      return res;
   endfunction
endpackage
`default_nettype wire

>>> hw/rtl/imh_slot_ram.sv
// Heap slot memory: one write port, two registered read ports.
// Depends on imh_pkg for the slot type.
`default_nettype none
module imh_slot_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [AW-1:0]     waddr,
   input  wire imh_pkg::slot_type wdata,
   input  wire logic [AW-1:0]     ra_addr,
   input  wire logic [AW-1:0]     rb_addr,
   output imh_pkg::slot_type      ra_data,
   output imh_pkg::slot_type      rb_data
);
   import imh_pkg::*;

   slot_type mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Two registered read ports.
   always_ff @(posedge clock) begin
      ra_data <= mem[ra_addr];
      rb_data <= mem[rb_addr];
   end
endmodule
`default_nettype wire

>>> hw/rtl/imh_id_ram.sv
// Id table memory: present flag and heap slot of every edge id.
// Depends on imh_pkg through an import; one write and one read port.
`default_nettype none
module imh_id_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 9
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata
);
   import imh_pkg::*;

   logic [DW-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

>>> hw/rtl/indexed_min_heap_engine.sv
// Indexed binary min-heap engine: sequencer over the slot and id memories.
// A transaction looks up the id table and, where needed, sifts the moving entry
// one heap level per step (at most log2(CAPACITY) levels) and places it.
// The sift loop does one memory read and write-back per level.
// One request is in flight at a time; the next is taken once the engine is back in idle.
// Reset: synchronous; a clearing pass over all ID_SPACE entries wipes the id table first.
`default_nettype none
`include "indexed_min_heap_engine_defines.svh"
module indexed_min_heap_engine #(
   parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
   parameter int ID_SPACE = imh_pkg::ID_SPACE_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [imh_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [imh_pkg::KEY_W-1:0]     req_dist_key,
   input  wire logic [imh_pkg::EDGE_ID_W-1:0] req_edge_id,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [imh_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_top_valid,
   output logic [imh_pkg::KEY_W-1:0]          rsp_top_key,
   output logic [imh_pkg::EDGE_ID_W-1:0]      rsp_top_id,
   output logic [imh_pkg::COUNT_W-1:0]        rsp_entry_count
);
   import imh_pkg::*;

   localparam int SW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int CHW = SW + 2;
   localparam int IW  = $clog2(ID_SPACE);
   localparam int IDW = SW + 1;

   // Map an edge id onto the id table address.
   function automatic logic [IW-1:0] id_index(input logic [EDGE_ID_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[IW-1:0];
   endfunction

   function automatic logic [SW-1:0] parent_of(input logic [SW-1:0] p);
      return (p - SW'(1)) >> 1;
   endfunction

   function automatic logic [CHW-1:0] left_of(input logic [SW-1:0] p);
      return (CHW'(p) << 1) + CHW'(1);
   endfunction

   // Control registers.
   state_type            state_ff, state_in;
   logic [IW-1:0]        clr_ff, clr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [SW-1:0]        pos_ff, pos_in;
   // Payload registers.
   mode_type             mode_ff, mode_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [EDGE_ID_W-1:0] id_ff, id_in;
   slot_type             cur_ff, cur_in;
   status_type           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_top_valid_ff, rsp_top_valid_in;
   logic [KEY_W-1:0]     rsp_top_key_ff, rsp_top_key_in;
   logic [EDGE_ID_W-1:0] rsp_top_id_ff, rsp_top_id_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // Memory ports.
   logic                 slot_we;
   logic [SW-1:0]        slot_waddr, slot_ra_addr, slot_rb_addr;
   slot_type             slot_wdata, slot_a, slot_b;
   logic                 idt_we;
   logic [IW-1:0]        idt_waddr, idt_raddr;
   logic [IDW-1:0]       idt_wdata, idt_rdata;

   imh_slot_ram #(.DEPTH(CAPACITY), .AW(SW)) u_slot_ram (
      .clock   (clock),
      .we      (slot_we),
      .waddr   (slot_waddr),
      .wdata   (slot_wdata),
      .ra_addr (slot_ra_addr),
      .rb_addr (slot_rb_addr),
      .ra_data (slot_a),
      .rb_data (slot_b)
   );

   imh_id_ram #(.DEPTH(ID_SPACE), .AW(IW), .DW(IDW)) u_id_ram (
      .clock (clock),
      .we    (idt_we),
      .waddr (idt_waddr),
      .wdata (idt_wdata),
      .raddr (idt_raddr),
      .rdata (idt_rdata)
   );

   // Shared decisions.
   logic            req_fire, out_go, id_in_range, id_present, ins_ok, era_ok, pop_ok;
   logic [SW-1:0]   id_slot_rd, par_pos;
   logic [CHW-1:0]  lc_pos, rc_pos, lc_new, rc_new;
   logic            cur_before_a, lc_ok, rc_ok, take_a, take_b, dn_move;
   slot_type        child;
   logic [SW-1:0]   child_pos;
   logic [31:0]     count_wide;

   assign req_fire    = req_valid && req_ready;
   assign out_go      = !rsp_valid_ff || rsp_ready;
   assign id_in_range = (32'(id_ff) < 32'(ID_SPACE));
   assign id_present  = idt_rdata[IDW-1];
   assign id_slot_rd  = idt_rdata[SW-1:0];
   assign ins_ok      = id_in_range && !id_present && (count_ff < CW'(CAPACITY));
   assign era_ok      = id_in_range && id_present && (CW'(id_slot_rd) < count_ff);
   assign pop_ok      = (count_ff != '0);
   assign par_pos     = parent_of(pos_ff);
   assign lc_pos      = left_of(pos_ff);
   assign rc_pos      = lc_pos + CHW'(1);
   assign cur_before_a = ranks_before(cur_ff, slot_a);
   assign lc_ok       = (lc_pos < CHW'(count_ff));
   assign rc_ok       = (rc_pos < CHW'(count_ff));
   assign take_a      = lc_ok && ranks_before(slot_a, cur_ff);
   assign take_b      = rc_ok && ranks_before(slot_b, take_a ? slot_a : cur_ff);
   assign dn_move     = take_a || take_b;
   assign child       = take_b ? slot_b : slot_a;
   assign child_pos   = take_b ? rc_pos[SW-1:0] : lc_pos[SW-1:0];
   assign lc_new      = left_of(child_pos);
   assign rc_new      = lc_new + CHW'(1);
   assign count_wide  = 32'(count_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IW'(ID_SPACE - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            case (mode_ff)
               MODE_INSERT: begin
                  if (!ins_ok) state_in = ST_FIN;
                  else if (count_ff == '0) state_in = ST_PLACE;
                  else state_in = ST_UP_CMP;
               end
               MODE_ERASE: state_in = era_ok ? ST_RM_CMP : ST_FIN;
               MODE_POP:   state_in = pop_ok ? ST_RM_CMP : ST_FIN;
               default:    state_in = ST_FIN;
            endcase
         end
         ST_RM_CMP: begin
            if (CW'(pos_ff) == count_ff) state_in = ST_FIN;
            else if (pos_ff != '0) state_in = ST_RM_UP;
            else state_in = ST_DN_CMP;
         end
         ST_RM_UP: begin
            if (!cur_before_a) state_in = ST_DN_CMP;
            else if (par_pos == '0) state_in = ST_PLACE;
            else state_in = ST_UP_CMP;
         end
         ST_UP_CMP: begin
            if (!cur_before_a || par_pos == '0) state_in = ST_PLACE;
         end
         ST_DN_CMP: begin
            if (!dn_move) state_in = ST_PLACE;
         end
         ST_PLACE: state_in = ST_FIN;
         ST_FIN:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_go) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Datapath, memory controls and output values.
   always_comb begin
      req_ready        = (state_ff == ST_IDLE);
      clr_in           = clr_ff;
      count_in         = count_ff;
      pos_in           = pos_ff;
      mode_in          = mode_ff;
      key_in           = key_ff;
      id_in            = id_ff;
      cur_in           = cur_ff;
      status_in        = status_ff;
      slot_we          = 1'b0;
      slot_waddr       = pos_ff;
      slot_wdata       = cur_ff;
      slot_ra_addr     = '0;
      slot_rb_addr     = '0;
      idt_we           = 1'b0;
      idt_waddr        = id_index(cur_ff.id);
      idt_wdata        = {1'b1, pos_ff};
      idt_raddr        = id_index(req_edge_id);
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_top_valid_in = rsp_top_valid_ff;
      rsp_top_key_in   = rsp_top_key_ff;
      rsp_top_id_in    = rsp_top_id_ff;
      rsp_count_in     = rsp_count_ff;
      case (state_ff)
         ST_CLEAR: begin
            // Sweep the id table to mark every id absent.
            idt_we    = 1'b1;
            idt_waddr = clr_ff;
            idt_wdata = '0;
            clr_in    = clr_ff + IW'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               mode_in = mode_type'(req_mode);
               key_in  = req_dist_key;
               id_in   = req_edge_id;
            end
         end
         ST_LOOK: begin
            // Check the id table and start the insert or the removal.
            status_in = STAT_OK;
            case (mode_ff)
               MODE_INSERT: begin
                  if (!id_in_range) status_in = STAT_NOT_FOUND;
                  else if (id_present) status_in = STAT_DUPLICATE;
                  else if (!ins_ok) status_in = STAT_FULL;
                  if (ins_ok) begin
                     pos_in       = count_ff[SW-1:0];
                     count_in     = count_ff + CW'(1);
                     cur_in.key   = key_ff;
                     cur_in.id    = id_ff;
                     slot_ra_addr = parent_of(count_ff[SW-1:0]);
                  end
               end
               MODE_ERASE: begin
                  if (!era_ok) status_in = STAT_NOT_FOUND;
                  else begin
                     pos_in       = id_slot_rd;
                     count_in     = count_ff - CW'(1);
                     slot_ra_addr = id_slot_rd;
                     slot_rb_addr = SW'(count_ff - CW'(1));
                  end
               end
               MODE_POP: begin
                  if (!pop_ok) status_in = STAT_EMPTY;
                  else begin
                     pos_in       = '0;
                     count_in     = count_ff - CW'(1);
                     slot_rb_addr = SW'(count_ff - CW'(1));
                  end
               end
               default: status_in = STAT_OK;
            endcase
         end
         ST_RM_CMP: begin
            // Drop the removed id and take the last entry as the moving one.
            idt_we       = 1'b1;
            idt_waddr    = id_index(slot_a.id);
            idt_wdata    = '0;
            cur_in       = slot_b;
            slot_ra_addr = (pos_ff == '0) ? lc_pos[SW-1:0] : par_pos;
            slot_rb_addr = rc_pos[SW-1:0];
         end
         ST_RM_UP, ST_UP_CMP: begin
            if (cur_before_a) begin
               // Parent moves down into the hole.
               slot_we      = 1'b1;
               slot_wdata   = slot_a;
               idt_we       = 1'b1;
               idt_waddr    = id_index(slot_a.id);
               pos_in       = par_pos;
               slot_ra_addr = parent_of(par_pos);
            end else if (state_ff == ST_RM_UP) begin
               slot_ra_addr = lc_pos[SW-1:0];
               slot_rb_addr = rc_pos[SW-1:0];
            end
         end
         ST_DN_CMP: begin
            if (dn_move) begin
               // Smaller child moves up into the hole.
               slot_we      = 1'b1;
               slot_wdata   = child;
               idt_we       = 1'b1;
               idt_waddr    = id_index(child.id);
               pos_in       = child_pos;
               slot_ra_addr = lc_new[SW-1:0];
               slot_rb_addr = rc_new[SW-1:0];
            end
         end
         ST_PLACE: begin
            slot_we = 1'b1;
            idt_we  = 1'b1;
         end
         ST_OUT: begin
            // Load the result register from the top slot.
            if (out_go) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = status_ff;
               rsp_top_valid_in = (count_ff != '0);
               rsp_top_key_in   = (count_ff != '0) ? slot_a.key : '0;
               rsp_top_id_in    = (count_ff != '0) ? slot_a.id : '0;
               rsp_count_in     = count_wide[COUNT_W-1:0];
            end
         end
         default: begin
            slot_ra_addr = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff           <= pos_in;
      mode_ff          <= mode_in;
      key_ff           <= key_in;
      id_ff            <= id_in;
      cur_ff           <= cur_in;
      status_ff        <= status_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_top_valid_ff <= rsp_top_valid_in;
      rsp_top_key_ff   <= rsp_top_key_in;
      rsp_top_id_ff    <= rsp_top_id_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_top_valid   = rsp_top_valid_ff;
   assign rsp_top_key     = rsp_top_key_ff;
   assign rsp_top_id      = rsp_top_id_ff;
   assign rsp_entry_count = rsp_count_ff;

   // Checks.
   `IMH_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count exceeds capacity")
   `IMH_ASSERT_NEXT(a_accept_look, clock, reset, req_valid && req_ready, state_ff == ST_LOOK, "accepted transaction not looked up")
   `IMH_ASSERT_NOW(a_pos_in_heap, clock, reset, state_ff == ST_UP_CMP || state_ff == ST_DN_CMP, CW'(pos_ff) < count_ff, "sift position outside heap")
   `IMH_ASSERT_NEXT(a_out_load, clock, reset, state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready), rsp_valid_ff, "result not presented")
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the indexed min-heap engine: directed table, then random traffic.
// Depends on imh_pkg and indexed_min_heap_engine; holds its own heap predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import imh_pkg::*;

   localparam int CAP = CAPACITY_DEF;
   localparam int IDS = ID_SPACE_DEF;
   localparam int LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [MODE_W-1:0] req_mode = '0;
   logic [KEY_W-1:0] req_dist_key = '0;
   logic [EDGE_ID_W-1:0] req_edge_id = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic rsp_top_valid;
   logic [KEY_W-1:0] rsp_top_key;
   logic [EDGE_ID_W-1:0] rsp_top_id;
   logic [COUNT_W-1:0] rsp_entry_count;

   indexed_min_heap_engine u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_dist_key(req_dist_key), .req_edge_id(req_edge_id),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_top_valid(rsp_top_valid), .rsp_top_key(rsp_top_key),
      .rsp_top_id(rsp_top_id), .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // One response as the heap should report it.
   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic                 top_valid;
      logic [KEY_W-1:0]     top_key;
      logic [EDGE_ID_W-1:0] top_id;
      logic [COUNT_W-1:0]   count;
   } heap_view_type;

   // Predictor state: a mirror of the heap and its id position table.
   slot_type      mirror_slot [CAP];
   int            id_pos [IDS];
   bit            id_held [IDS];
   int            held;
   heap_view_type pending_views[$];
   int            errors = 0;
   int            cycles = 0;
   int            sent = 0, seen = 0, n_ins = 0, n_dup = 0, n_full = 0, n_miss = 0;
   int            send_idle_pct = 0, recv_idle_pct = 0;
   bit            hold_rsp = 1'b0;

   function automatic bit earlier(slot_type a, slot_type b);
      if (a.key != b.key) return a.key < b.key;
      return a.id < b.id;
   endfunction

   function automatic void swap_slots(int a, int b);
      slot_type t;
      t = mirror_slot[a];
      mirror_slot[a] = mirror_slot[b];
      mirror_slot[b] = t;
      id_pos[mirror_slot[a].id] = a;
      id_pos[mirror_slot[b].id] = b;
   endfunction

   function automatic void sift_up(int p);
      while (p > 0 && earlier(mirror_slot[p], mirror_slot[(p - 1) / 2])) begin
         swap_slots(p, (p - 1) / 2);
         p = (p - 1) / 2;
      end
   endfunction

   function automatic void sift_down(int p);
      int best;
      forever begin
         best = p;
         if (2 * p + 1 < held && earlier(mirror_slot[2 * p + 1], mirror_slot[best]))
            best = 2 * p + 1;
         if (2 * p + 2 < held && earlier(mirror_slot[2 * p + 2], mirror_slot[best]))
            best = 2 * p + 2;
         if (best == p) break;
         swap_slots(best, p);
         p = best;
      end
   endfunction

   function automatic void take_out(int p);
      id_held[mirror_slot[p].id] = 1'b0;
      held--;
      if (p != held) begin
         mirror_slot[p] = mirror_slot[held];
         id_pos[mirror_slot[p].id] = p;
         if (p > 0 && earlier(mirror_slot[p], mirror_slot[(p - 1) / 2])) sift_up(p);
         else sift_down(p);
      end
   endfunction

   // Apply one transaction to the mirror and return the response it should give.
   function automatic heap_view_type heap_apply(mode_type m, logic [KEY_W-1:0] k,
                                                logic [EDGE_ID_W-1:0] id);
      heap_view_type v;
      v = '0;
      v.status = STAT_OK;
      case (m)
         MODE_INSERT: begin
            if (id_held[id]) v.status = STAT_DUPLICATE;
            else if (held >= CAP) v.status = STAT_FULL;
            else begin
               mirror_slot[held] = '{key: k, id: id};
               id_pos[id] = held;
               id_held[id] = 1'b1;
               held++;
               sift_up(held - 1);
            end
         end
         MODE_ERASE: begin
            if (!id_held[id]) v.status = STAT_NOT_FOUND;
            else take_out(id_pos[id]);
         end
         MODE_POP: begin
            if (held == 0) v.status = STAT_EMPTY;
            else take_out(0);
         end
         default: ;
      endcase
      if (held > 0) begin
         v.top_valid = 1'b1;
         v.top_key = mirror_slot[0].key;
         v.top_id = mirror_slot[0].id;
      end
      v.count = COUNT_W'(held);
      return v;
   endfunction

   task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
      errors++;
      $display("mismatch on %s: got %0h, expected %0h (response %0d)", what, got, want, seen);
   endtask

   // Send one transaction; with typed set, the given expectation is checked instead.
   task automatic send_item(mode_type m, logic [KEY_W-1:0] k, logic [EDGE_ID_W-1:0] id,
                            bit typed = 1'b0, heap_view_type want = '0);
      heap_view_type v;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_dist_key <= k;
      req_edge_id <= id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      v = heap_apply(m, k, id);
      if (typed && v != want) report_mismatch("directed table row", 128'(v), 128'(want));
      pending_views.insert(pending_views.size(), typed ? want : v);
      case (v.status)
         STAT_OK: if (m == MODE_INSERT) n_ins++;
         STAT_DUPLICATE: n_dup++;
         STAT_FULL: n_full++;
         STAT_NOT_FOUND: n_miss++;
         default: ;
      endcase
      sent++;
   endtask

   // Stop offering and wait until every expected response has come.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_views.size() != 0) @(negedge clock);
   endtask

   // Receiver: random back-pressure, plus a long hold-off when asked.
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   // Response checker, sampled at the rising edge.
   always @(posedge clock) begin
      heap_view_type w;
      cycles++;
      if (cycles > LIMIT) begin
         $display("status: fail");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         seen++;
         if (pending_views.size() == 0) begin
            report_mismatch("unexpected response", 128'(rsp_status), 128'(0));
         end else begin
            w = pending_views.pop_front();
            if (rsp_status != w.status)
               report_mismatch("status", 128'(rsp_status), 128'(w.status));
            if (rsp_top_valid != w.top_valid)
               report_mismatch("top_valid", 128'(rsp_top_valid), 128'(w.top_valid));
            if (rsp_top_key != w.top_key)
               report_mismatch("top_key", 128'(rsp_top_key), 128'(w.top_key));
            if (rsp_top_id != w.top_id)
               report_mismatch("top_id", 128'(rsp_top_id), 128'(w.top_id));
            if (rsp_entry_count != w.count)
               report_mismatch("entry_count", 128'(rsp_entry_count), 128'(w.count));
         end
      end
   end

   // Directed stimulus row.
   typedef struct {
      mode_type             m;
      logic [KEY_W-1:0]     k;
      logic [EDGE_ID_W-1:0] id;
      bit                   typed;
      heap_view_type        want;
   } dir_row_type;

   localparam logic [KEY_W-1:0] KMAX = {KEY_W{1'b1}};

   dir_row_type rows[$];

   // Append one row to the directed table.
   task automatic add_row(mode_type m, logic [KEY_W-1:0] k, logic [EDGE_ID_W-1:0] id,
                          bit typed, heap_view_type want);
      dir_row_type r;
      r.m = m;
      r.k = k;
      r.id = id;
      r.typed = typed;
      r.want = want;
      rows.insert(rows.size(), r);
   endtask

   // Pick an id: mostly held ones for erases, a small pool so duplicates occur.
   function automatic logic [EDGE_ID_W-1:0] pick_id(bit want_held);
      logic [EDGE_ID_W-1:0] id;
      id = EDGE_ID_W'($urandom_range(IDS - 1));
      if (want_held && held > 0) id = mirror_slot[$urandom_range(held - 1)].id;
      else if ($urandom_range(3) == 0) id = EDGE_ID_W'($urandom_range(63));
      return id;
   endfunction

   // Pick an id that the heap does not hold.
   function automatic logic [EDGE_ID_W-1:0] free_id();
      logic [EDGE_ID_W-1:0] id;
      id = EDGE_ID_W'($urandom_range(IDS - 1));
      while (id_held[id]) id = id + EDGE_ID_W'(1);
      return id;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(4))
         0: return '0;
         1: return KMAX;
         2: return KEY_W'($urandom_range(15));
         default: return KEY_W'({$urandom, $urandom});
      endcase
   endfunction

   task automatic random_phase(int n, int ins_bias);
      int r;
      repeat (n) begin
         r = $urandom_range(99);
         if (r < ins_bias) send_item(MODE_INSERT, pick_key(), pick_id(0));
         else if (r < ins_bias + 20)
            send_item(MODE_ERASE, '0, pick_id($urandom_range(4) != 0));
         else if (r < ins_bias + 35)
            send_item(MODE_POP, KEY_W'({$urandom, $urandom}), EDGE_ID_W'($urandom));
         else send_item(MODE_PEEK, KEY_W'({$urandom, $urandom}), EDGE_ID_W'($urandom));
      end
   endtask

   initial begin
      heap_view_type e;
      for (int i = 0; i < IDS; i++) id_held[i] = 1'b0;
      held = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty-heap cases, then extremes of key and id, ties, erases and misses.
      e = '{status: STAT_OK, top_valid: 0, top_key: 0, top_id: 0, count: 0};
      add_row(MODE_PEEK, KMAX, 10'h3ff, 1, e);
      e.status = STAT_EMPTY;
      add_row(MODE_POP, '0, '0, 1, e);
      e.status = STAT_NOT_FOUND;
      add_row(MODE_ERASE, '0, 10'd5, 1, e);
      e = '{status: STAT_OK, top_valid: 1, top_key: KMAX, top_id: 10'h3ff, count: 1};
      add_row(MODE_INSERT, KMAX, 10'h3ff, 1, e);
      e.status = STAT_DUPLICATE;
      add_row(MODE_INSERT, '0, 10'h3ff, 1, e);
      e = '{status: STAT_OK, top_valid: 1, top_key: 0, top_id: 0, count: 2};
      add_row(MODE_INSERT, '0, '0, 1, e);
      add_row(MODE_INSERT, '0, 10'd7, 0, e);
      add_row(MODE_INSERT, 62'd3, 10'd2, 0, e);
      add_row(MODE_INSERT, 62'd3, 10'd1, 0, e);
      add_row(MODE_INSERT, KMAX - 1, 10'd9, 0, e);
      add_row(MODE_INSERT, 62'h2aaaaaaaaaaaaaaa, 10'h155, 0, e);
      add_row(MODE_INSERT, 62'h1555555555555555, 10'h2aa, 0, e);
      add_row(MODE_ERASE, '0, 10'd0, 0, e);
      add_row(MODE_ERASE, '0, 10'd2, 0, e);
      add_row(MODE_ERASE, '0, 10'd2, 0, e);
      add_row(MODE_POP, '0, '0, 0, e);
      add_row(MODE_PEEK, '0, '0, 0, e);
      add_row(MODE_ERASE, KMAX, 10'h3ff, 0, e);
      add_row(MODE_POP, '0, '0, 0, e);
      foreach (rows[i]) send_item(rows[i].m, rows[i].k, rows[i].id, rows[i].typed, rows[i].want);

      // Sender idles more gently than the receiver, then the other way round.
      send_idle_pct = 34; recv_idle_pct = 45;
      random_phase(80, 45);

      // Long receiver hold-off so the block backs up and stalls its input.
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         random_phase(6, 50);
      join
      wait_drained();

      send_idle_pct = 45; recv_idle_pct = 34;
      random_phase(60, 40);

      // Fill the heap to capacity, test the full case, then shrink it again.
      send_idle_pct = 0; recv_idle_pct = 0;
      while (held < CAP)
         send_item(MODE_INSERT, pick_key(), EDGE_ID_W'($urandom_range(IDS - 1)));
      send_item(MODE_INSERT, '0, free_id());
      send_item(MODE_INSERT, KMAX, mirror_slot[0].id);
      random_phase(40, 30);
      random_phase(150, 10);
      wait_drained();
      repeat (40) @(negedge clock);

      $display("sent %0d transactions, %0d responses: %0d inserts, %0d duplicates,",
               sent, seen, n_ins, n_dup);
      $display("%0d full rejects, %0d missing-id erases, heap filled to capacity once",
               n_full, n_miss);
      if (errors == 0 && pending_views.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
